>>> hw/rtl/pctd_pkg.sv
package pctd_pkg;

    localparam int CODE_W = 16;
    localparam int LEN_W = 5;
    localparam int SYM_W = 8;

    typedef logic [CODE_W-1:0] t_code;
    typedef logic [LEN_W-1:0] t_len;
    typedef logic [SYM_W-1:0] t_sym;

    typedef enum logic [1:0] {
        MODE_LOAD   = 2'd0,
        MODE_DECODE = 2'd1,
        MODE_CLEAR  = 2'd2
    } t_mode;

    typedef enum logic {
        STATUS_OK       = 1'b0,
        STATUS_NO_MATCH = 1'b1
    } t_status;

    typedef struct packed {
        logic  lookup;
        logic  load;
        logic  clear;
        t_code key_code;
        t_len  key_len;
        t_sym  load_symbol;
    } t_cam_req;

    typedef struct packed {
        logic hit;
        t_sym symbol;
    } t_cam_rsp;

endpackage

>>> hw/rtl/pctd_cam.sv
module pctd_cam #(
    parameter int MAX_ENTRIES = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pctd_pkg::t_cam_req i_req,
    output pctd_pkg::t_cam_rsp o_rsp
);

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    pctd_pkg::t_code r_code [MAX_ENTRIES];
    pctd_pkg::t_len  r_len  [MAX_ENTRIES];
    pctd_pkg::t_sym  r_sym  [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] r_valid;
    logic [CNT_W-1:0]       r_count;

    logic [MAX_ENTRIES-1:0] match;
    logic                   hit;
    pctd_pkg::t_sym         hit_sym;
    logic                   append;

    always_comb begin
        hit_sym = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            match[i] = r_valid[i] && (r_len[i] == i_req.key_len) &&
                       (r_code[i] == i_req.key_code) && (i_req.lookup || i_req.load);
            hit_sym = hit_sym | (match[i] ? r_sym[i] : '0);
        end
        hit = |match;
    end

    assign append = i_req.load && !hit && (r_count < CNT_W'(MAX_ENTRIES));

    assign o_rsp.hit = hit;
    assign o_rsp.symbol = hit_sym;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
        end else if (i_req.clear) begin
            r_valid <= '0;
            r_count <= '0;
        end else if (append) begin
            r_valid[r_count[$clog2(MAX_ENTRIES)-1:0]] <= 1'b1;
            r_count <= r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (append && (r_count == CNT_W'(i))) begin
                r_code[i] <= i_req.key_code;
                r_len[i]  <= i_req.key_len;
                r_sym[i]  <= i_req.load_symbol;
            end else if (i_req.load && match[i]) begin
                r_sym[i] <= i_req.load_symbol;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ENTRIES))
        else $error("entry count above table depth");

    a_count_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_count))
        else $error("entry count disagrees with valid bits");

    a_unique_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(match))
        else $error("more than one table entry matched");

endmodule

>>> hw/rtl/prefix_code_table_decoder.sv
// Prefix code decoder with a loadable table. Each request is a load (add a code with its
// byte, or replace the byte of a code already stored), a decode (shift in one bit) or a
// clear. A decode compares the gathered bits against every table entry at once and returns
// the byte on an exact match; after MAX_CODE_LEN bits without a match it returns a no-match
// status with a zero byte. One request is taken every cycle: the whole table compare sits
// between the state registers and the output register, and a new request is accepted
// whenever the output register is empty or is being read in the same cycle.
module prefix_code_table_decoder #(
    parameter int MAX_ENTRIES  = 256,
    parameter int MAX_CODE_LEN = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // Fields from bit 0: code_bits[15:0], code_length[4:0], load_symbol[7:0], in_bit.
    input  logic [31:0] i_s_tdata,
    // Fields from bit 0: mode[1:0].
    input  logic [1:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // Fields from bit 0: out_symbol[7:0].
    output logic [7:0]  o_m_tdata,
    // Fields from bit 0: status.
    output logic        o_m_tuser
);

    localparam int ACC_LEN_W = $clog2(MAX_CODE_LEN + 1);

    pctd_pkg::t_code      r_acc_bits;
    logic [ACC_LEN_W-1:0] r_acc_len;
    logic                 r_out_valid;
    pctd_pkg::t_sym       r_out_sym;
    pctd_pkg::t_status    r_out_status;

    pctd_pkg::t_code      n_acc_bits;
    logic [ACC_LEN_W-1:0] n_acc_len;

    pctd_pkg::t_code      in_code;
    pctd_pkg::t_len       in_len;
    pctd_pkg::t_sym       in_sym;
    logic                 in_bit;
    pctd_pkg::t_mode      in_mode;
    pctd_pkg::t_code      len_mask;
    logic                 accept;
    logic                 len_ok;
    logic                 out_take;
    logic                 out_result;
    pctd_pkg::t_cam_req   cam_req;
    pctd_pkg::t_cam_rsp   cam_rsp;

    assign in_code = i_s_tdata[15:0];
    assign in_len  = i_s_tdata[20:16];
    assign in_sym  = i_s_tdata[28:21];
    assign in_bit  = i_s_tdata[29];
    assign in_mode = pctd_pkg::t_mode'(i_s_tuser);

    assign out_take   = r_out_valid && i_m_tready;
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;

    assign n_acc_bits = {r_acc_bits[pctd_pkg::CODE_W-2:0], in_bit};
    assign n_acc_len  = r_acc_len + 1'b1;

    assign out_result = accept && (in_mode == pctd_pkg::MODE_DECODE) &&
                        (cam_rsp.hit || (int'(n_acc_len) >= MAX_CODE_LEN));

    assign len_ok = (in_len != '0) && (int'(in_len) <= pctd_pkg::CODE_W) &&
                    (int'(in_len) <= MAX_CODE_LEN);

    always_comb begin
        for (int j = 0; j < pctd_pkg::CODE_W; j++) begin
            len_mask[j] = (j < int'(in_len));
        end
    end

    always_comb begin
        cam_req = '0;
        cam_req.load_symbol = in_sym;
        case (in_mode)
            pctd_pkg::MODE_LOAD: begin
                cam_req.load     = accept && len_ok;
                cam_req.key_code = in_code & len_mask;
                cam_req.key_len  = in_len;
            end
            pctd_pkg::MODE_DECODE: begin
                cam_req.lookup   = accept && (int'(n_acc_len) <= pctd_pkg::CODE_W);
                cam_req.key_code = n_acc_bits;
                cam_req.key_len  = pctd_pkg::LEN_W'(n_acc_len);
            end
            pctd_pkg::MODE_CLEAR: begin
                cam_req.clear = accept;
            end
            default: begin
                cam_req = '0;
            end
        endcase
    end

    pctd_cam #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_cam (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (cam_req),
        .o_rsp  (cam_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_bits  <= '0;
            r_acc_len   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_result) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
            if (accept && (in_mode == pctd_pkg::MODE_CLEAR)) begin
                r_acc_bits <= '0;
                r_acc_len  <= '0;
            end else if (accept && (in_mode == pctd_pkg::MODE_DECODE)) begin
                if (out_result) begin
                    r_acc_bits <= '0;
                    r_acc_len  <= '0;
                end else begin
                    r_acc_bits <= n_acc_bits;
                    r_acc_len  <= n_acc_len;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_result) begin
            if (cam_rsp.hit) begin
                r_out_sym    <= cam_rsp.symbol;
                r_out_status <= pctd_pkg::STATUS_OK;
            end else begin
                r_out_sym    <= '0;
                r_out_status <= pctd_pkg::STATUS_NO_MATCH;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_sym;
    assign o_m_tuser  = r_out_status;

    a_acc_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_acc_len) < MAX_CODE_LEN)
        else $error("accumulator reached maximum code length without a result");

    a_acc_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_acc_len == '0) |-> (r_acc_bits == '0))
        else $error("empty accumulator holds bits");

    a_error_symbol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == pctd_pkg::STATUS_NO_MATCH)) |-> (r_out_sym == '0))
        else $error("no-match result carries a nonzero symbol");

endmodule

>>> bench/tb_prefix_code_table_decoder.sv
module tb_prefix_code_table_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = 256;
    localparam int MAX_LEN = 16;
    localparam int RANDOM_ITEMS = 80;
    localparam int LONG_HOLD = 80;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT = 300000;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct {
        pctd_pkg::t_sym    symbol;
        pctd_pkg::t_status status;
    } t_decoded;

    class decode_scoreboard;
        pctd_pkg::t_code stored_code[TABLE_DEPTH];
        pctd_pkg::t_len  stored_len[TABLE_DEPTH];
        pctd_pkg::t_sym  stored_sym[TABLE_DEPTH];
        int unsigned     stored_count = 0;
        pctd_pkg::t_code acc_bits = '0;
        int unsigned     acc_len = 0;
        t_decoded        pending_q[$];
        int unsigned     n_mismatch = 0;
        int unsigned     n_symbols = 0;
        int unsigned     n_no_match = 0;
        int unsigned     n_loads = 0;
        int unsigned     n_decodes = 0;
        int unsigned     n_clears = 0;
        int unsigned     n_unused = 0;

        function void report(string what);
            n_mismatch++;
            if (n_mismatch <= 10) begin
                $display("[%0t] mismatch: %s", $realtime, what);
            end
        endfunction

        function void note_request(logic [1:0] mode, pctd_pkg::t_code bits,
                                   pctd_pkg::t_len len, pctd_pkg::t_sym sym, logic bit_in);
            int unsigned     idx;
            pctd_pkg::t_code masked;
            bit              hit;
            t_decoded        res;
            hit = 1'b0;
            case (mode)
                pctd_pkg::MODE_LOAD: begin
                    n_loads++;
                    if (len != 0 && len <= MAX_LEN && len <= pctd_pkg::CODE_W) begin
                        masked = bits & pctd_pkg::t_code'((32'd1 << len) - 32'd1);
                        for (idx = 0; idx < stored_count; idx++) begin
                            if (!hit && stored_len[idx] == len &&
                                stored_code[idx] == masked) begin
                                stored_sym[idx] = sym;
                                hit = 1'b1;
                            end
                        end
                        if (!hit && stored_count < TABLE_DEPTH) begin
                            stored_code[stored_count] = masked;
                            stored_len[stored_count] = len;
                            stored_sym[stored_count] = sym;
                            stored_count++;
                        end
                    end
                end
                pctd_pkg::MODE_DECODE: begin
                    n_decodes++;
                    acc_bits = {acc_bits[pctd_pkg::CODE_W-2:0], bit_in};
                    acc_len++;
                    for (idx = 0; idx < stored_count; idx++) begin
                        if (!hit && stored_len[idx] == acc_len &&
                            stored_code[idx] == acc_bits) begin
                            res.symbol = stored_sym[idx];
                            res.status = pctd_pkg::STATUS_OK;
                            hit = 1'b1;
                        end
                    end
                    if (!hit && acc_len >= MAX_LEN) begin
                        res.symbol = '0;
                        res.status = pctd_pkg::STATUS_NO_MATCH;
                        hit = 1'b1;
                    end
                    if (hit) begin
                        pending_q.push_back(res);
                        acc_bits = '0;
                        acc_len = 0;
                    end
                end
                pctd_pkg::MODE_CLEAR: begin
                    n_clears++;
                    stored_count = 0;
                    acc_bits = '0;
                    acc_len = 0;
                end
                default: begin
                    n_unused++;
                end
            endcase
        endfunction

        function void check_result(pctd_pkg::t_sym sym, logic stat);
            t_decoded want;
            if (pending_q.size() == 0) begin
                report($sformatf("result with nothing pending: symbol %02h status %0d",
                                 sym, stat));
            end else begin
                want = pending_q.pop_front();
                if (sym !== want.symbol || stat !== want.status) begin
                    report($sformatf("expected symbol %02h status %0d, got symbol %02h status %0d",
                                     want.symbol, want.status, sym, stat));
                end else if (want.status == pctd_pkg::STATUS_OK) begin
                    n_symbols++;
                end else begin
                    n_no_match++;
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tuser;

    decode_scoreboard sb = new();
    pctd_pkg::t_code  leaf_code[$];
    int unsigned      leaf_len[$];
    int unsigned      n_sent = 0;
    int unsigned      tx_calm_left = 0;
    int unsigned      cycle_count = 0;
    int unsigned      n_long_holds = 0;
    bit               long_hold_req = 1'b0;

    prefix_code_table_decoder #(
        .MAX_ENTRIES (TABLE_DEPTH),
        .MAX_CODE_LEN(MAX_LEN)
    ) i_dut (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_s_tvalid(s_tvalid),
        .o_s_tready(s_tready),
        .i_s_tdata (s_tdata),
        .i_s_tuser (s_tuser),
        .o_m_tvalid(m_tvalid),
        .i_m_tready(m_tready),
        .o_m_tdata (m_tdata),
        .o_m_tuser (m_tuser)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    task automatic send_request(logic [1:0] mode, pctd_pkg::t_code bits, pctd_pkg::t_len len,
                                pctd_pkg::t_sym sym, logic bit_in);
        int unsigned gap;
        if (tx_calm_left > 0) begin
            tx_calm_left--;
            gap = 0;
        end else begin
            gap = pick_gap();
            if ($urandom_range(0, 24) == 0) begin
                tx_calm_left = $urandom_range(20, 60);
            end
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            s_tdata <= $urandom() & 32'h3FFF_FFFF;
            s_tuser <= 2'($urandom());
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, bit_in, sym, len, bits};
        s_tuser <= mode;
        do @(posedge clk); while (!s_tready);
        sb.note_request(mode, bits, len, sym, bit_in);
        if (mode != MODE_UNUSED) begin
            n_sent++;
        end
        @(negedge clk);
    endtask

    task automatic load_code(pctd_pkg::t_code bits, pctd_pkg::t_len len, pctd_pkg::t_sym sym);
        send_request(pctd_pkg::MODE_LOAD, bits, len, sym, 1'($urandom()));
    endtask

    task automatic decode_bit(logic b);
        send_request(pctd_pkg::MODE_DECODE, pctd_pkg::t_code'($urandom()),
                     pctd_pkg::t_len'($urandom()), pctd_pkg::t_sym'($urandom()), b);
    endtask

    task automatic clear_request();
        send_request(pctd_pkg::MODE_CLEAR, pctd_pkg::t_code'($urandom()),
                     pctd_pkg::t_len'($urandom()), pctd_pkg::t_sym'($urandom()),
                     1'($urandom()));
    endtask

    task automatic send_code(pctd_pkg::t_code code, int unsigned len);
        for (int k = int'(len) - 1; k >= 0; k--) begin
            decode_bit(code[k]);
        end
    endtask

    // Builds a complete prefix code by splitting leaves, then loads it into an empty table.
    task automatic build_table();
        int unsigned     splits;
        int unsigned     idx;
        pctd_pkg::t_code c;
        int unsigned     l;
        clear_request();
        leaf_code.delete();
        leaf_len.delete();
        leaf_code.push_back('0);
        leaf_len.push_back(0);
        splits = $urandom_range(1, 24);
        repeat (splits) begin
            idx = ($urandom_range(0, 1) == 0) ? leaf_code.size() - 1
                                              : $urandom_range(0, leaf_code.size() - 1);
            if (leaf_len[idx] < MAX_LEN) begin
                c = leaf_code[idx];
                l = leaf_len[idx];
                leaf_code.delete(idx);
                leaf_len.delete(idx);
                leaf_code.push_back(c << 1);
                leaf_len.push_back(l + 1);
                leaf_code.push_back((c << 1) | pctd_pkg::t_code'(1));
                leaf_len.push_back(l + 1);
            end
        end
        foreach (leaf_code[i]) begin
            load_code(leaf_code[i] | (pctd_pkg::t_code'($urandom()) << leaf_len[i]),
                      pctd_pkg::t_len'(leaf_len[i]), pctd_pkg::t_sym'($urandom()));
        end
    endtask

    initial begin
        int unsigned stall_left;
        int unsigned calm_left;
        int unsigned g;
        stall_left = 0;
        calm_left = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                n_long_holds++;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (calm_left > 0) begin
                calm_left--;
                m_tready <= 1'b1;
            end else begin
                g = pick_gap();
                if ($urandom_range(0, 19) == 0) begin
                    calm_left = $urandom_range(20, 60);
                end
                stall_left = (g > 0) ? g - 1 : 0;
                m_tready <= (g == 0);
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            sb.check_result(m_tdata, m_tuser);
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Run stopped after %0d cycles with %0d results outstanding", cycle_count,
                     sb.pending_q.size());
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        int unsigned start;
        int unsigned r;
        int unsigned idx;
        bit          pressure_done;
        pressure_done = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = pctd_pkg::MODE_LOAD;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Loads that can never match are dropped, and junk above the code length is ignored.
        load_code(16'hFFFF, 5'd0, 8'hFF);
        load_code(16'hFFFF, 5'd17, 8'h00);
        load_code(16'h0000, 5'd31, 8'hFF);
        load_code(16'hFFFE, 5'd1, 8'hA5);
        load_code(16'hFFFF, 5'd16, 8'hFF);
        // The two-bit code is shadowed by the shorter one that is its prefix.
        load_code(16'h0000, 5'd2, 8'h00);
        load_code(16'h7FFE, 5'd1, 8'h5A);
        send_request(MODE_UNUSED, 16'hFFFF, 5'h1F, 8'hFF, 1'b1);
        decode_bit(1'b0);
        decode_bit(1'b0);
        send_code(16'hFFFF, 16);
        clear_request();
        decode_bit(1'b0);

        // Fill the table to its last entry, then try to add one more and replace one.
        clear_request();
        for (int i = 0; i < TABLE_DEPTH - 1; i++) begin
            load_code({8'($urandom()), 8'(i)}, 5'd8, pctd_pkg::t_sym'($urandom()));
        end
        load_code({7'($urandom()), 9'h1FE}, 5'd9, pctd_pkg::t_sym'($urandom()));
        load_code({7'($urandom()), 9'h1FF}, 5'd9, pctd_pkg::t_sym'($urandom()));
        load_code({8'($urandom()), 8'd7}, 5'd8, 8'hC3);
        send_code(16'hFFFF, 16);
        send_code(16'h01FE, 9);
        send_code(16'h0007, 8);
        repeat (2) send_code(pctd_pkg::t_code'($urandom_range(0, TABLE_DEPTH - 2)), 8);

        start = n_sent;
        build_table();
        while (n_sent - start < RANDOM_ITEMS) begin
            if (!pressure_done && n_sent - start > RANDOM_ITEMS / 3) begin
                pressure_done = 1'b1;
                long_hold_req = 1'b1;
                tx_calm_left = 60;
                repeat (40) decode_bit(1'($urandom()));
            end
            r = $urandom_range(0, 99);
            if (r < 10) begin
                repeat ($urandom_range(1, 4)) begin
                    send_request(2'($urandom()), pctd_pkg::t_code'($urandom()),
                                 pctd_pkg::t_len'($urandom()), pctd_pkg::t_sym'($urandom()),
                                 1'($urandom()));
                end
            end else if (r < 18) begin
                build_table();
            end else if (r < 26) begin
                repeat ($urandom_range(1, 3)) begin
                    load_code(pctd_pkg::t_code'($urandom()),
                              pctd_pkg::t_len'($urandom_range(1, MAX_LEN)),
                              pctd_pkg::t_sym'($urandom()));
                end
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    idx = $urandom_range(0, leaf_code.size() - 1);
                    send_code(leaf_code[idx], leaf_len[idx]);
                end
                if ($urandom_range(0, 9) == 0) begin
                    repeat ($urandom_range(1, 5)) decode_bit(1'($urandom()));
                end
            end
        end

        s_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Requests: %0d loads, %0d decodes, %0d clears, %0d with the unused mode.",
                 sb.n_loads, sb.n_decodes, sb.n_clears, sb.n_unused);
        $display("Checked %0d decoded bytes and %0d no-match results; %0d long output stalls.",
                 sb.n_symbols, sb.n_no_match, n_long_holds);
        if (sb.n_mismatch == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
